// File: sv/sfcp_pkg.sv
// Package with shared types, constants and the CRC byte fold for the frame packer.
`timescale 1ns / 1ps
package sfcp_pkg;

  // Frame and CRC constants.
  localparam int CHANNELS = 8;
  localparam int CNT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Queue between the front and the back part.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified sample as it waits in the queue.
  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } item_t;

  // Byte phase of the back part.
  typedef enum logic [1:0] {
    PH_LO,
    PH_HI,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_t;

  // Fold one byte into a reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: sv/sfcp_fifo.sv
// Short register queue that decouples the front and back parts.
`timescale 1ns / 1ps
module sfcp_fifo import sfcp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  q_full,
  input  logic  rd_en,
  output logic  q_valid,
  output item_t rd_item
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_wr, do_rd;

  // Status and head of the queue.
  assign q_full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign rd_item = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && q_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// File: sv/sfcp_front.sv
// Front part: takes samples, tracks the channel slot and marks the last channel.
`timescale 1ns / 1ps
module sfcp_front import sfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_sample,
  input  logic        push,
  input  logic        q_full,
  output logic        q_wr,
  output item_t       q_item
);

  logic [CNT_W-1:0] chan_r, chan_nxt;
  logic             is_last;

  // A sample at or beyond the final slot closes the frame.
  assign is_last       = ({1'b0, chan_r} >= (CNT_W + 1)'(CHANNELS - 1));
  assign q_wr          = push && !q_full;
  assign q_item.sample = in_sample;
  assign q_item.last   = is_last;

  // Channel slot counter advances on every input transfer.
  always_comb begin
    chan_nxt = chan_r;
    if (q_wr) begin
      chan_nxt = is_last ? '0 : chan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= '0;
    end else begin
      chan_r <= chan_nxt;
    end
  end

endmodule

// File: sv/sfcp_back.sv
// Back part: emits frame bytes one per cycle unless stalled; keeps the running CRC.
`timescale 1ns / 1ps
module sfcp_back import sfcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_rd,
  output logic [7:0] out_tx_byte,
  output logic       out_frame_end,
  output logic       empty,
  input  logic       pop
);

  phase_t      state_r, state_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_end_r, out_end_nxt;
  logic        advance;

  assign empty         = !out_valid_r;
  assign out_tx_byte   = out_byte_r;
  assign out_frame_end = out_end_r;

  // The output register takes a new byte when it is free or being drained.
  assign advance = !out_valid_r || pop;

  // Byte sequencer: sample low, sample high, then the CRC bytes on the last channel.
  always_comb begin
    state_nxt     = state_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !pop;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    q_rd          = 1'b0;
    if (advance) begin
      case (state_r)
        PH_LO: begin
          if (q_valid) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = q_item.sample[7:0];
            out_end_nxt   = 1'b0;
            crc_nxt       = crc_fold(crc_r, q_item.sample[7:0]);
            state_nxt     = PH_HI;
          end
        end
        PH_HI: begin
          if (q_valid) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = q_item.sample[15:8];
            out_end_nxt   = 1'b0;
            crc_nxt       = crc_fold(crc_r, q_item.sample[15:8]);
            q_rd          = 1'b1;
            state_nxt     = q_item.last ? PH_CRC_LO : PH_LO;
          end
        end
        PH_CRC_LO: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_r[7:0];
          out_end_nxt   = 1'b0;
          state_nxt     = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_r[15:8];
          out_end_nxt   = 1'b1;
          crc_nxt       = CRC_INIT;
          state_nxt     = PH_LO;
        end
        default: begin
          state_nxt = PH_LO;
        end
      endcase
    end
  end

  // Control state and CRC.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PH_LO;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

endmodule

// File: sv/scope_frame_crc16_packer.sv
// Top level of the CRC-16 framed sample packer.
//
//   channel | ports                        | transfer when
//   --------+------------------------------+-------------------
//   input   | in_sample, push, full        | push && !full
//   result  | out_tx_byte, out_frame_end,  | pop && !empty
//           | empty, pop                   |
//
// Each sample yields two bytes, and the last channel of a frame four; the back
// part emits one byte per cycle unless pop or an empty queue holds it back.
// A four-entry queue lets samples arrive while earlier bytes are still pending.
// Reset is synchronous, active low; it clears the channel slot, the CRC to 0xFFFF,
// the queue and the output valid flag. A stalled pop holds the byte in place.
`timescale 1ns / 1ps
module scope_frame_crc16_packer import sfcp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] in_sample,
  input  logic        push,
  output logic        full,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end,
  output logic        empty,
  input  logic        pop
);

  logic  q_wr, q_rd, q_full, q_valid;
  item_t q_wr_item, q_rd_item;

  assign full = q_full;

  // Front part classifies each sample.
  sfcp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sample (in_sample),
    .push      (push),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_item    (q_wr_item)
  );

  // Queue between the two parts.
  sfcp_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_item (q_wr_item),
    .q_full  (q_full),
    .rd_en   (q_rd),
    .q_valid (q_valid),
    .rd_item (q_rd_item)
  );

  // Back part emits bytes and the CRC.
  sfcp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_item        (q_rd_item),
    .q_rd          (q_rd),
    .out_tx_byte   (out_tx_byte),
    .out_frame_end (out_frame_end),
    .empty         (empty),
    .pop           (pop)
  );

endmodule

// File: dv/scope_frame_crc16_packer_test.sv
// Self-checking testbench for the CRC-16 framed sample packer.
`timescale 1ns / 1ps
module scope_frame_crc16_packer_test import sfcp_pkg::*;;

  // The run stops at this limit on its total length, e.g. if the byte stream stalls for good.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PER_PHASE = 71;

  // One frame byte as it is expected on the result ports.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Scoreboard: builds the expected byte stream from accepted samples.
  class frame_byte_checker;
    frame_byte_t pending_bytes[$];
    int unsigned slot;
    logic [15:0] crc_acc;
    int          errors;

    function new();
      slot = 0;
      crc_acc = 16'hFFFF;
      errors = 0;
    endfunction

    // Reflected CRC-16 update, least significant bit first.
    function logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] data);
      logic [15:0] r;
      r = acc;
      for (int i = 0; i < 8; i++) begin
        if (r[0] ^ data[i]) begin
          r = {1'b0, r[15:1]} ^ 16'hA001;
        end else begin
          r = {1'b0, r[15:1]};
        end
      end
      return r;
    endfunction

    function void push_byte(input logic [7:0] data, input logic last);
      frame_byte_t fb;
      fb.data = data;
      fb.last = last;
      pending_bytes.push_back(fb);
    endfunction

    // An accepted sample adds two bytes, and four when it closes a frame.
    function void note_sample(input logic [15:0] s);
      push_byte(s[7:0], 1'b0);
      push_byte(s[15:8], 1'b0);
      crc_acc = crc_update(crc_acc, s[7:0]);
      crc_acc = crc_update(crc_acc, s[15:8]);
      if (slot + 1 >= CHANNELS) begin
        push_byte(crc_acc[7:0], 1'b0);
        push_byte(crc_acc[15:8], 1'b1);
        slot = 0;
        crc_acc = 16'hFFFF;
      end else begin
        slot++;
      end
    endfunction

    task report(input string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Compare one transferred byte with the oldest expected one.
    task check_byte(input logic [7:0] data, input logic last);
      frame_byte_t fb;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h with nothing expected", data));
      end else begin
        fb = pending_bytes.pop_front();
        if (data !== fb.data) begin
          report($sformatf("tx_byte %02h, expected %02h", data, fb.data));
        end
        if (last !== fb.last) begin
          report($sformatf("frame_end %b, expected %b", last, fb.last));
        end
      end
    endtask

    task check_drained();
      if (pending_bytes.size() != 0) begin
        report($sformatf("%0d bytes never arrived", pending_bytes.size()));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [15:0] in_sample = '0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  out_tx_byte;
  logic        out_frame_end;
  logic        empty;
  logic        pop = 1'b0;

  int send_idle_pct = 36;
  int recv_idle_pct = 59;
  int hold_left = 0;
  int cycles = 0;
  frame_byte_checker sb = new();

  scope_frame_crc16_packer uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_sample    (in_sample),
    .push         (push),
    .full         (full),
    .out_tx_byte  (out_tx_byte),
    .out_frame_end(out_frame_end),
    .empty        (empty),
    .pop          (pop)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("scope_frame_crc16_packer regression: fail");
      $finish;
    end
  end

  // Receiver: checks each transfer, then picks pop for the next cycle.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        sb.check_byte(out_tx_byte, out_frame_end);
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one sample, with a random gap first, and wait for its transfer.
  task automatic send_sample(input logic [15:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    push <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (full);
    sb.note_sample(s);
  endtask

  // Mostly uniform samples, with extremes and sparse patterns mixed in.
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return $urandom_range(1) ? 16'h0000 : 16'hFFFF;
      3: return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_sample(pick_sample());
    end
  endtask

  // Main sequence: reset, directed frames, three random phases, drain.
  initial begin
    logic [15:0] directed[16];
    directed = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0001, 16'h00FF,
                 16'hFF00, 16'h5555, 16'hAAAA, 16'h1234, 16'h8001, 16'h7FFE,
                 16'h0100, 16'h00FE, 16'hFFFE, 16'hC3A5};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two whole frames of edge values.
    foreach (directed[i]) begin
      send_sample(directed[i]);
    end
    run_random(RANDOM_PER_PHASE);

    send_idle_pct = 59;
    recv_idle_pct = 36;
    run_random(RANDOM_PER_PHASE);

    // No idling; the receiver first holds off so the queue fills up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 200;
    run_random(RANDOM_PER_PHASE);
    push <= 1'b0;

    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("scope_frame_crc16_packer regression: pass");
    end else begin
      $display("scope_frame_crc16_packer regression: fail");
    end
    $finish;
  end

endmodule
